// ===== rtl/obbp_pkg.sv =====
`default_nettype none
package obbp_pkg;

    localparam int unsigned LEN_W = 31;
    localparam int unsigned LIM_W = 21;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [LIM_W-1:0] LIM_RESET = 21'd128;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;

    typedef logic [2:0] corner_t;
    typedef corner_t [7:0] corner_set_t;

    typedef struct packed {
        logic signed [31:0] dot0;
        logic signed [31:0] dot1;
        logic signed [31:0] dot2;
        logic signed [35:0] origin;
    } dot_bus_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [33:0] mulq30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    function automatic corner_set_t face_corners(input logic [1:0] ax, input logic pos);
        corner_set_t c;
        logic [2:0] s;
        c = '0;
        s = {ax, pos};
        unique case (s)
            3'b000: c = {3'd4, 3'd6, 3'd2, 3'd0, 3'd1, 3'd3, 3'd7, 3'd5};
            3'b001: c = {3'd1, 3'd3, 3'd7, 3'd5, 3'd4, 3'd6, 3'd2, 3'd0};
            3'b010: c = {3'd0, 3'd1, 3'd5, 3'd4, 3'd6, 3'd7, 3'd3, 3'd2};
            3'b011: c = {3'd6, 3'd7, 3'd3, 3'd2, 3'd0, 3'd1, 3'd5, 3'd4};
            3'b100: c = {3'd2, 3'd3, 3'd1, 3'd0, 3'd4, 3'd5, 3'd7, 3'd6};
            3'b101: c = {3'd4, 3'd5, 3'd7, 3'd6, 3'd2, 3'd3, 3'd1, 3'd0};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [11:0] edge_corners(input logic [1:0] k, input logic pa,
                                                 input logic pb);
        logic [11:0] e;
        logic [3:0] s;
        e = '0;
        s = {k, pa, pb};
        unique case (s)
            4'b0000: e = {3'd6, 3'd7, 3'd0, 3'd1};
            4'b0001: e = {3'd2, 3'd3, 3'd4, 3'd5};
            4'b0010: e = {3'd4, 3'd5, 3'd2, 3'd3};
            4'b0011: e = {3'd0, 3'd1, 3'd6, 3'd7};
            4'b0100: e = {3'd5, 3'd7, 3'd0, 3'd2};
            4'b0101: e = {3'd1, 3'd3, 3'd4, 3'd6};
            4'b0110: e = {3'd4, 3'd6, 3'd1, 3'd3};
            4'b0111: e = {3'd0, 3'd2, 3'd5, 3'd7};
            4'b1000: e = {3'd3, 3'd7, 3'd0, 3'd4};
            4'b1001: e = {3'd1, 3'd5, 3'd2, 3'd6};
            4'b1010: e = {3'd2, 3'd6, 3'd1, 3'd5};
            4'b1011: e = {3'd0, 3'd4, 3'd3, 3'd7};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/obbp_matrix.sv =====
`default_nettype none
module obbp_matrix
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic signed [31:0]  qw,
    input  wire logic signed [31:0]  qx,
    input  wire logic signed [31:0]  qy,
    input  wire logic signed [31:0]  qz,
    output logic                     out_valid,
    output logic signed [31:0]       m_out [9]
);

    logic               v1_reg, v2_reg;
    logic signed [33:0] p_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [33:0] p_next [9];
    logic signed [31:0] m_next [9];
    logic signed [35:0] one;

    always_comb
    begin
        one = 36'sd1073741824;
        p_next[0] = obbp_pkg::mulq30(qx, qx);
        p_next[1] = obbp_pkg::mulq30(qy, qy);
        p_next[2] = obbp_pkg::mulq30(qz, qz);
        p_next[3] = obbp_pkg::mulq30(qx, qy);
        p_next[4] = obbp_pkg::mulq30(qx, qz);
        p_next[5] = obbp_pkg::mulq30(qy, qz);
        p_next[6] = obbp_pkg::mulq30(qw, qx);
        p_next[7] = obbp_pkg::mulq30(qw, qy);
        p_next[8] = obbp_pkg::mulq30(qw, qz);
        m_next[0] = obbp_pkg::sat32(one - 36'(2 * (36'(p_reg[1]) + 36'(p_reg[2]))));
        m_next[1] = obbp_pkg::sat32(36'(2 * (36'(p_reg[3]) + 36'(p_reg[8]))));
        m_next[2] = obbp_pkg::sat32(36'(2 * (36'(p_reg[4]) - 36'(p_reg[7]))));
        m_next[3] = obbp_pkg::sat32(36'(2 * (36'(p_reg[3]) - 36'(p_reg[8]))));
        m_next[4] = obbp_pkg::sat32(one - 36'(2 * (36'(p_reg[0]) + 36'(p_reg[2]))));
        m_next[5] = obbp_pkg::sat32(36'(2 * (36'(p_reg[5]) + 36'(p_reg[6]))));
        m_next[6] = obbp_pkg::sat32(36'(2 * (36'(p_reg[4]) + 36'(p_reg[7]))));
        m_next[7] = obbp_pkg::sat32(36'(2 * (36'(p_reg[5]) - 36'(p_reg[6]))));
        m_next[8] = obbp_pkg::sat32(one - 36'(2 * (36'(p_reg[0]) + 36'(p_reg[1]))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        m_reg <= m_next;
    end

    assign out_valid = v2_reg;
    assign m_out     = m_reg;

endmodule
`default_nettype wire

// ===== rtl/obbp_dot.sv =====
`default_nettype none
module obbp_dot
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic signed [31:0]    m_in [9],
    input  wire logic signed [31:0]    d_in [3],
    input  wire logic signed [31:0]    p_in [3],
    output logic                       out_valid,
    output obbp_pkg::dot_bus_t         dots
);

    logic               v1_reg, v2_reg;
    logic signed [33:0] t_reg [12];
    logic signed [33:0] t_next [12];
    obbp_pkg::dot_bus_t dots_reg, dots_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                t_next[i*3+j] = obbp_pkg::mulq30(d_in[j], m_in[i*3+j]);
            t_next[9+i] = obbp_pkg::mulq30(d_in[i], p_in[i]);
        end
        dots_next.dot0 = obbp_pkg::sat32(36'(t_reg[0]) + 36'(t_reg[1]) + 36'(t_reg[2]));
        dots_next.dot1 = obbp_pkg::sat32(36'(t_reg[3]) + 36'(t_reg[4]) + 36'(t_reg[5]));
        dots_next.dot2 = obbp_pkg::sat32(36'(t_reg[6]) + 36'(t_reg[7]) + 36'(t_reg[8]));
        dots_next.origin = 36'(t_reg[9]) + 36'(t_reg[10]) + 36'(t_reg[11]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        dots_reg <= dots_next;
    end

    assign out_valid = v2_reg;
    assign dots      = dots_reg;

endmodule
`default_nettype wire

// ===== rtl/obbp_classify.sv =====
`default_nettype none
module obbp_classify
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire obbp_pkg::dot_bus_t    dots,
    input  wire logic [30:0]           len_x,
    input  wire logic [30:0]           len_y,
    input  wire logic [30:0]           len_z,
    input  wire logic [20:0]           limit,
    output logic                       out_valid,
    output logic [1:0]                 kind,
    output obbp_pkg::corner_set_t      corners,
    output logic signed [31:0]         low,
    output logic signed [31:0]         high
);

    logic                 v1_reg, v2_reg;
    logic [31:0]          mag [3];
    logic [30:0]          len [3];
    logic signed [31:0]   dv [3];
    logic [2:0]           zr, ps;
    logic [31:0]          term_reg [3];
    logic [31:0]          term_next [3];
    logic [62:0]          prod [3];
    logic [2:0]           zr_reg, ps_reg;
    logic signed [35:0]   org_reg;
    logic [1:0]           kind_next, kind_reg;
    obbp_pkg::corner_set_t c_next, c_reg;
    logic signed [31:0]   low_reg, high_reg, low_next, high_next;
    logic [33:0]          ext;
    logic [1:0]           k, fa;
    logic                 pa, pb;
    logic [11:0]          e;
    logic [2:0]           c0;

    always_comb
    begin
        dv[0] = dots.dot0;
        dv[1] = dots.dot1;
        dv[2] = dots.dot2;
        len[0] = len_x;
        len[1] = len_y;
        len[2] = len_z;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = dv[i][31] ? 32'(-33'(dv[i])) : 32'(dv[i]);
            zr[i] = {1'b0, mag[i]} < {12'd0, limit};
            ps[i] = (dv[i] > 32'sd0);
            prod[i] = mag[i] * len[i];
            term_next[i] = 32'(prod[i] >> 31);
        end
    end

    always_comb
    begin
        kind_next = obbp_pkg::KIND_VERTEX;
        c_next = '0;
        ext = '0;
        fa = 2'd0;
        k = 2'd0;
        pa = 1'b0;
        pb = 1'b0;
        e = '0;
        c0 = '0;
        priority if (zr_reg[0] && zr_reg[1])
        begin
            kind_next = obbp_pkg::KIND_FACE;
            fa = 2'd2;
            ext = 34'(term_reg[2]);
            c_next = obbp_pkg::face_corners(fa, ps_reg[2]);
        end
        else if (zr_reg[0] && zr_reg[2])
        begin
            kind_next = obbp_pkg::KIND_FACE;
            fa = 2'd1;
            ext = 34'(term_reg[1]);
            c_next = obbp_pkg::face_corners(fa, ps_reg[1]);
        end
        else if (zr_reg[1] && zr_reg[2])
        begin
            kind_next = obbp_pkg::KIND_FACE;
            ext = 34'(term_reg[0]);
            c_next = obbp_pkg::face_corners(fa, ps_reg[0]);
        end
        else if (|zr_reg)
        begin
            kind_next = obbp_pkg::KIND_EDGE;
            k = zr_reg[0] ? 2'd0 : (zr_reg[1] ? 2'd1 : 2'd2);
            pa = (k == 2'd0) ? ps_reg[1] : ps_reg[0];
            pb = (k == 2'd2) ? ps_reg[1] : ps_reg[2];
            ext = (k == 2'd0) ? 34'(term_reg[1]) + 34'(term_reg[2]) :
                  (k == 2'd1) ? 34'(term_reg[0]) + 34'(term_reg[2]) :
                                34'(term_reg[0]) + 34'(term_reg[1]);
            e = obbp_pkg::edge_corners(k, pa, pb);
            c_next[0] = e[11:9];
            c_next[1] = e[8:6];
            c_next[6] = e[5:3];
            c_next[7] = e[2:0];
        end
        else
        begin
            ext = 34'(term_reg[0]) + 34'(term_reg[1]) + 34'(term_reg[2]);
            c0 = {~ps_reg[2], ~ps_reg[1], ~ps_reg[0]};
            c_next[0] = c0;
            c_next[7] = ~c0;
        end
        low_next  = obbp_pkg::sat32(org_reg - 36'({2'b00, ext}));
        high_next = obbp_pkg::sat32(org_reg + 36'({2'b00, ext}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        zr_reg   <= zr;
        ps_reg   <= ps;
        org_reg  <= dots.origin;
        kind_reg <= kind_next;
        c_reg    <= c_next;
        low_reg  <= low_next;
        high_reg <= high_next;
    end

    assign out_valid = v2_reg;
    assign kind      = kind_reg;
    assign corners   = c_reg;
    assign low       = low_reg;
    assign high      = high_reg;

    property p_low_le_high;
        @(posedge clk) disable iff (!rst_n) v2_reg |-> (low_reg <= high_reg);
    endproperty
    a_low_le_high: assert property (p_low_le_high) else $error("interval inverted");

    property p_kind_code;
        @(posedge clk) disable iff (!rst_n)
            v2_reg |-> (kind_reg != 2'd3);
    endproperty
    a_kind_code: assert property (p_kind_code) else $error("bad kind");

    property p_vertex_opp;
        @(posedge clk) disable iff (!rst_n)
            (v2_reg && kind_reg == obbp_pkg::KIND_VERTEX) |-> (c_reg[7] == ~c_reg[0]);
    endproperty
    a_vertex_opp: assert property (p_vertex_opp) else $error("vertex corners mismatch");

endmodule
`default_nettype wire

// ===== rtl/obb_axis_projection_config_unit.sv =====
// An accepted start flows through the matrix, dot and classify stages to the done strobe.
// Throughput: one request per cycle; busy stays low, a fully pipelined 6-stage datapath.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset: asynchronous active-low; clears pipeline valid bits, side lengths to 0,
// near-zero limit to 128.
`default_nettype none
module obb_axis_projection_config_unit
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic signed [31:0] dir_z,
    input  wire logic signed [31:0] rot_w,
    input  wire logic signed [31:0] rot_x,
    input  wire logic signed [31:0] rot_y,
    input  wire logic signed [31:0] rot_z,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    done,
    output logic [1:0]              contact_kind,
    output logic [2:0]              corner_0,
    output logic [2:0]              corner_1,
    output logic [2:0]              corner_2,
    output logic [2:0]              corner_3,
    output logic [2:0]              corner_4,
    output logic [2:0]              corner_5,
    output logic [2:0]              corner_6,
    output logic [2:0]              corner_7,
    output logic signed [31:0]      proj_low,
    output logic signed [31:0]      proj_high
);

    logic [30:0]        len_x_reg, len_y_reg, len_z_reg;
    logic [20:0]        limit_reg;
    logic               mat_valid, dot_valid;
    logic signed [31:0] m [9];
    logic signed [31:0] d_pipe_reg [2][3];
    logic signed [31:0] p_pipe_reg [2][3];
    obbp_pkg::dot_bus_t dots;
    obbp_pkg::corner_set_t corners;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_x_reg <= '0;
            len_y_reg <= '0;
            len_z_reg <= '0;
            limit_reg <= obbp_pkg::LIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                obbp_pkg::REG_LEN_X: len_x_reg <= cfg_data[30:0];
                obbp_pkg::REG_LEN_Y: len_y_reg <= cfg_data[30:0];
                obbp_pkg::REG_LEN_Z: len_z_reg <= cfg_data[30:0];
                obbp_pkg::REG_LIMIT: limit_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // hold direction and centre alongside the matrix stages
    always_ff @(posedge clk)
    begin
        d_pipe_reg[0] <= '{dir_x, dir_y, dir_z};
        p_pipe_reg[0] <= '{pos_x, pos_y, pos_z};
        d_pipe_reg[1] <= d_pipe_reg[0];
        p_pipe_reg[1] <= p_pipe_reg[0];
    end

    obbp_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .qw        (rot_w),
        .qx        (rot_x),
        .qy        (rot_y),
        .qz        (rot_z),
        .out_valid (mat_valid),
        .m_out     (m)
    );

    obbp_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .m_in      (m),
        .d_in      (d_pipe_reg[1]),
        .p_in      (p_pipe_reg[1]),
        .out_valid (dot_valid),
        .dots      (dots)
    );

    obbp_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .dots      (dots),
        .len_x     (len_x_reg),
        .len_y     (len_y_reg),
        .len_z     (len_z_reg),
        .limit     (limit_reg),
        .out_valid (done),
        .kind      (contact_kind),
        .corners   (corners),
        .low       (proj_low),
        .high      (proj_high)
    );

    assign corner_0 = corners[0];
    assign corner_1 = corners[1];
    assign corner_2 = corners[2];
    assign corner_3 = corners[3];
    assign corner_4 = corners[4];
    assign corner_5 = corners[5];
    assign corner_6 = corners[6];
    assign corner_7 = corners[7];

endmodule
`default_nettype wire
